@@ rtl/gedn_pkg.sv @@
// Package for the gamepad event decode and normalize block.
// Holds codes, limits and the structs shared by gedn_state, gedn_norm and the top level.
// No dependencies.
package gedn_pkg;

  // Build constants
  localparam int unsigned BUTTON_COUNT  = 16;
  localparam int unsigned SETTLE_FRAMES = 30;

  // Operation codes (s_tuser low bits)
  localparam logic [1:0] OP_EVENT     = 2'd0;
  localparam logic [1:0] OP_FRAME     = 2'd1;
  localparam logic [1:0] OP_RECONNECT = 2'd2;

  // Event types and codes
  localparam logic [15:0] EV_KEY       = 16'd1;
  localparam logic [15:0] EV_ABS       = 16'd3;
  localparam logic [15:0] ABS_X        = 16'd0;
  localparam logic [15:0] ABS_Y        = 16'd1;
  localparam logic [15:0] KEY_BASE_JOY = 16'h0120;
  localparam logic [15:0] KEY_BASE_PAD = 16'h0130;

  // Button mask for the configured count
  localparam logic [15:0] BTN_MASK = 16'((32'd1 << BUTTON_COUNT) - 32'd1);

  // Configuration register indexes
  localparam logic [2:0] CFG_X_LOW  = 3'd0;
  localparam logic [2:0] CFG_X_HIGH = 3'd1;
  localparam logic [2:0] CFG_Y_LOW  = 3'd2;
  localparam logic [2:0] CFG_Y_HIGH = 3'd3;
  localparam logic [2:0] CFG_DEAD   = 3'd4;

  // Reset values of the configuration registers
  localparam logic signed [15:0] LIMIT_LOW_RST  = -16'sd32768;
  localparam logic signed [15:0] LIMIT_HIGH_RST = 16'sd32767;
  localparam logic [14:0]        DEAD_ZONE_RST  = 15'd4915;

  // Q1.15 saturation values
  localparam logic signed [15:0] Q15_MAX = 16'sd32767;
  localparam logic signed [15:0] Q15_MIN = -16'sd32768;

  // Number of quotient bits produced by the divider
  localparam int unsigned DIV_STEPS = 15;

  // One axis: raw sample and its calibration limits
  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } axis_t;

  // Button and settle status handed to the output stage
  typedef struct packed {
    logic [15:0] held;
    logic [15:0] pressed;
    logic        settling;
  } btn_status_t;

endpackage

@@ rtl/gamepad_event_decode_normalize_top.sv @@
// Each accepted item works both axes in turn through the shared 15-step divider; an axis whose
// range is not positive or that saturates skips the division, and a held result stalls the load.
// A new item is not taken before the result of the last one is loaded into the output register.
// s_tready is high only while the sequencer is idle; the result register may still hold.
// Reset (rst, synchronous): config to defaults, buttons and samples zero, settle count 30.
// Top level; instantiates gedn_state and gedn_norm, uses gedn_pkg.
module gamepad_event_decode_normalize_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // event_code[15:0], event_value[47:16]
  input  logic [17:0] s_tuser,   // operation[1:0], event_type[17:2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // held_mask, pressed_mask, axis_x_norm, axis_y_norm, settling
);
  import gedn_pkg::*;

  logic        accept;
  logic        idle;
  axis_t       axis_x, axis_y;
  logic [14:0] dead_zone;
  btn_status_t status;

  assign s_tready = idle;
  assign accept   = s_tvalid && s_tready;

  gedn_state u_state (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .operation   (s_tuser[1:0]),
    .event_type  (s_tuser[17:2]),
    .event_code  (s_tdata[15:0]),
    .event_value (s_tdata[47:16]),
    .axis_x      (axis_x),
    .axis_y      (axis_y),
    .dead_zone   (dead_zone),
    .status      (status)
  );

  gedn_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .idle      (idle),
    .axis_x    (axis_x),
    .axis_y    (axis_y),
    .dead_zone (dead_zone),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ rtl/gedn_state.sv @@
// Event decoder and state registers: config registers, held/previous buttons,
// axis samples and the settle counter. Depends on gedn_pkg.
module gedn_state (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 accept,
  input  logic [1:0]           operation,
  input  logic [15:0]          event_type,
  input  logic [15:0]          event_code,
  input  logic signed [31:0]   event_value,
  output gedn_pkg::axis_t      axis_x,
  output gedn_pkg::axis_t      axis_y,
  output logic [14:0]          dead_zone,
  output gedn_pkg::btn_status_t status
);
  import gedn_pkg::*;

  logic signed [15:0] x_low_limit, x_high_limit, y_low_limit, y_high_limit;
  logic signed [15:0] x_sample, y_sample;
  logic [15:0]        buttons_now, buttons_before;
  logic [7:0]         settle_left;

  logic [15:0] joy_off, pad_off;
  logic        joy_hit, pad_hit, key_hit;
  logic [3:0]  btn_idx;
  logic [15:0] btn_bit;

  // Key code to button index
  always_comb begin
    joy_off = event_code - KEY_BASE_JOY;
    pad_off = event_code - KEY_BASE_PAD;
    joy_hit = joy_off < 16'(BUTTON_COUNT);
    pad_hit = pad_off < 16'(BUTTON_COUNT);
    key_hit = joy_hit || pad_hit;
    btn_idx = joy_hit ? joy_off[3:0] : pad_off[3:0];
    btn_bit = 16'd1 << btn_idx;
  end

  // Config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low_limit  <= LIMIT_LOW_RST;
      x_high_limit <= LIMIT_HIGH_RST;
      y_low_limit  <= LIMIT_LOW_RST;
      y_high_limit <= LIMIT_HIGH_RST;
      dead_zone    <= DEAD_ZONE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_LOW:  x_low_limit  <= cfg_data;
        CFG_X_HIGH: x_high_limit <= cfg_data;
        CFG_Y_LOW:  y_low_limit  <= cfg_data;
        CFG_Y_HIGH: y_high_limit <= cfg_data;
        CFG_DEAD:   dead_zone    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Event state update, one item at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      buttons_now    <= '0;
      buttons_before <= '0;
      x_sample       <= '0;
      y_sample       <= '0;
      settle_left    <= 8'(SETTLE_FRAMES);
    end else if (accept) begin
      case (operation)
        OP_EVENT: begin
          if (event_type == EV_ABS) begin
            if (event_code == ABS_X) x_sample <= event_value[15:0];
            else if (event_code == ABS_Y) y_sample <= event_value[15:0];
          end else if (event_type == EV_KEY && key_hit) begin
            if (event_value != '0) buttons_now <= buttons_now | btn_bit;
            else buttons_now <= buttons_now & ~btn_bit;
          end
        end
        OP_FRAME: begin
          if (settle_left != '0) settle_left <= settle_left - 8'd1;
          buttons_before <= buttons_now;
        end
        OP_RECONNECT: begin
          buttons_now    <= '0;
          buttons_before <= '0;
          x_sample       <= '0;
          y_sample       <= '0;
        end
        default: ;
      endcase
    end
  end

  assign axis_x = '{sample: x_sample, lo: x_low_limit, hi: x_high_limit};
  assign axis_y = '{sample: y_sample, lo: y_low_limit, hi: y_high_limit};
  assign status = '{held:     buttons_now & BTN_MASK,
                    pressed:  buttons_now & ~buttons_before & BTN_MASK,
                    settling: settle_left != '0};

endmodule

@@ rtl/gedn_norm.sv @@
// Axis normalizer: sequencer around one shared restoring divider that works
// both axes in turn, plus the output register. Depends on gedn_pkg.
module gedn_norm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  idle,
  input  gedn_pkg::axis_t       axis_x,
  input  gedn_pkg::axis_t       axis_y,
  input  logic [14:0]           dead_zone,
  input  gedn_pkg::btn_status_t status,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [71:0]           m_tdata   // held, pressed, axis_x_norm, axis_y_norm, settling, pad
);
  import gedn_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CENTRE = 7'b0000010,
    S_PREP   = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   axis_sel;                    // 0 X, 1 Y
  logic [3:0] cnt;

  axis_t cur;
  logic signed [16:0] lim_sum;
  logic signed [15:0] centre;
  logic signed [16:0] c_off, rng_hi, rng_lo;
  logic [15:0] rem, range_q;
  logic [14:0] quo;
  logic        c_pos, zero_out, sat;
  logic signed [15:0] x_res, y_res;

  // Datapath intermediates
  logic signed [16:0] rng_sel;
  logic        c_pos_w;
  logic [15:0] mag_w;
  logic [16:0] rem_sh;
  logic        ge;
  logic signed [15:0] fin_val;
  logic        out_free;

  assign cur      = axis_sel ? axis_y : axis_x;
  assign lim_sum  = 17'(cur.lo) + 17'(cur.hi);
  assign out_free = !m_tvalid || m_tready;
  assign idle     = state == S_IDLE;

  // Range, sign and magnitude of the centred sample
  always_comb begin
    c_pos_w = !c_off[16] && (c_off != '0);
    rng_sel = c_pos_w ? rng_hi : rng_lo;
    mag_w   = c_off[16] ? 16'(-c_off) : c_off[15:0];
  end

  // One restoring division step
  always_comb begin
    rem_sh = {rem, 1'b0};
    ge     = rem_sh >= {1'b0, range_q};
  end

  // Dead zone, saturation and sign
  always_comb begin
    if (zero_out) fin_val = '0;
    else if (sat) fin_val = c_pos ? Q15_MAX : Q15_MIN;
    else if (quo < dead_zone) fin_val = '0;
    else if (c_pos) fin_val = {1'b0, quo};
    else fin_val = -$signed({1'b0, quo});
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_CENTRE;
      S_CENTRE: state_next = S_PREP;
      S_PREP:   state_next = S_CHECK;
      S_CHECK: begin
        if (rng_sel[16] || rng_sel == '0 || mag_w >= rng_sel[15:0]) state_next = S_FIN;
        else state_next = S_DIV;
      end
      S_DIV:    if (cnt == 4'(DIV_STEPS - 1)) state_next = S_FIN;
      S_FIN:    state_next = axis_sel ? S_DONE : S_CENTRE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      axis_sel <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) axis_sel <= 1'b0;
      else if (state == S_FIN) axis_sel <= 1'b1;
      if (state == S_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_CENTRE: centre <= 16'((lim_sum + 17'(lim_sum[16])) >>> 1);
      S_PREP: begin
        c_off  <= 17'(cur.sample) - 17'(centre);
        rng_hi <= 17'(cur.hi) - 17'(centre);
        rng_lo <= 17'(centre) - 17'(cur.lo);
      end
      S_CHECK: begin
        c_pos    <= c_pos_w;
        zero_out <= rng_sel[16] || rng_sel == '0;
        sat      <= mag_w >= rng_sel[15:0];
        range_q  <= rng_sel[15:0];
        rem      <= mag_w;
        quo      <= '0;
        cnt      <= '0;
      end
      S_DIV: begin
        rem <= ge ? 16'(rem_sh - {1'b0, range_q}) : rem_sh[15:0];
        quo <= {quo[13:0], ge};
        cnt <= cnt + 4'd1;
      end
      S_FIN: begin
        if (axis_sel) y_res <= fin_val;
        else x_res <= fin_val;
      end
      S_DONE: begin
        if (out_free) begin
          m_tdata <= {7'd0, status.settling, y_res, x_res, status.pressed, status.held};
        end
      end
      default: ;
    endcase
  end

  // Remainder stays below the divisor during division
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < range_q) else $error("divider remainder out of range");

  // Step counter never runs past the quotient width
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt <= 4'(DIV_STEPS - 1)) else $error("divider step count overrun");

  // A start is only taken while idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE) else $error("start while busy");

  // Leaving DONE loads a result
  a_done_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (state == S_IDLE && m_tvalid))
    else $error("result not loaded");

endmodule
